### design/pressure_brightness_smoother_macros.svh
// ----------------------------------------------------------------------------
// pressure_brightness_smoother_macros.svh
// Assertion helpers used by the smoother sequencer (pbs_ctrl).
// ----------------------------------------------------------------------------
`ifndef PRESSURE_BRIGHTNESS_SMOOTHER_MACROS_SVH
`define PRESSURE_BRIGHTNESS_SMOOTHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbs assertion failed");

// Next-cycle implication, checked outside reset.
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbs assertion failed");

`endif

### design/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Types, constants and helper functions for the brightness smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

  localparam int KEYS  = 16;
  localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;

  localparam int DIV_STEPS = 8;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCKED_LEVEL   = 2'd0,
    REG_UNLOCKED_LEVEL = 2'd1,
    REG_PRESSURE_START = 2'd2
  } cfg_reg_t;

  localparam logic [7:0]  LOCKED_LEVEL_RST   = 8'd170;
  localparam logic [7:0]  UNLOCKED_LEVEL_RST = 8'd45;
  localparam logic [15:0] PRESSURE_START_RST = 16'd475;

  typedef struct packed {
    logic [3:0]  key_index;
    logic        has_locks;
    logic [15:0] cal_min;
    logic [15:0] cal_max;
    logic [15:0] reading;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic range;
    logic offs;
    logic num;
    logic div_step;
    logic mul;
    logic tgt;
    logic slew;
    logic color;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

  function automatic rgb_t palette_rgb(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'd128, 8'd48,  8'd0};
      4'd1:    c = '{8'd128, 8'd88,  8'd0};
      4'd2:    c = '{8'd112, 8'd128, 8'd0};
      4'd3:    c = '{8'd56,  8'd128, 8'd0};
      4'd4:    c = '{8'd0,   8'd128, 8'd24};
      4'd5:    c = '{8'd0,   8'd128, 8'd88};
      4'd6:    c = '{8'd0,   8'd112, 8'd128};
      4'd7:    c = '{8'd0,   8'd56,  8'd128};
      4'd8:    c = '{8'd0,   8'd0,   8'd128};
      4'd9:    c = '{8'd56,  8'd0,   8'd128};
      4'd10:   c = '{8'd104, 8'd0,   8'd128};
      4'd11:   c = '{8'd128, 8'd0,   8'd96};
      4'd12:   c = '{8'd128, 8'd0,   8'd40};
      4'd13:   c = '{8'd128, 8'd24,  8'd48};
      4'd14:   c = '{8'd96,  8'd48,  8'd128};
      default: c = '{8'd48,  8'd96,  8'd128};
    endcase
    return c;
  endfunction

  // floor(x / 255), exact for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

### design/pbs_ctrl.sv
// ----------------------------------------------------------------------------
// pbs_ctrl
// Sequencer: walks one transaction through the datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pressure_brightness_smoother_macros.svh"

module pbs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pbs_pkg::sts_t sts,
  output pbs_pkg::cmd_t      cmd
);
  import pbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RANGE, S_OFFS, S_NUM, S_DIV, S_MUL, S_TGT, S_SLEW, S_COLOR, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_RANGE;
      S_RANGE: state_nxt = S_OFFS;
      S_OFFS:  state_nxt = S_NUM;
      S_NUM: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_TGT;
      S_TGT:   state_nxt = S_SLEW;
      S_SLEW:  state_nxt = S_COLOR;
      S_COLOR: state_nxt = S_FIN;
      S_FIN:   if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // no transaction is taken while reset is held
  assign in_ready = rst_n && (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_ready && in_valid;
    cmd.range    = (state_r == S_RANGE);
    cmd.offs     = (state_r == S_OFFS);
    cmd.num      = (state_r == S_NUM);
    cmd.div_step = (state_r == S_DIV);
    cmd.mul      = (state_r == S_MUL);
    cmd.tgt      = (state_r == S_TGT);
    cmd.slew     = (state_r == S_SLEW);
    cmd.color    = (state_r == S_COLOR);
    cmd.out_load = (state_r == S_FIN) && !sts.out_busy;
  end

  `PBS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd.capture, !in_ready)
  `PBS_ASSERT_NEXT(a_div_len, clk, rst_n, state_r == S_DIV && cnt_r == CNT_LAST, cmd.mul)
  `PBS_ASSERT_NEXT(a_load_to_idle, clk, rst_n, cmd.out_load, in_ready)
  `PBS_ASSERT_NOW(a_one_step, clk, rst_n, cmd.div_step, $onehot(cmd))

endmodule

`default_nettype wire

### design/pbs_dp.sv
// ----------------------------------------------------------------------------
// pbs_dp
// Datapath: config registers, pressure mapping, serial divider, slew,
// per-key level store, color scaling and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pbs_pkg::in_item_t                 in_data,
  output pbs_pkg::out_item_t                     out_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  input  wire logic                              cfg_we,
  input  wire logic [pbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire pbs_pkg::cmd_t                     cmd,
  output pbs_pkg::sts_t                          sts
);
  import pbs_pkg::*;

  // configuration
  logic [7:0]  locked_level_r, unlocked_level_r;
  logic [15:0] pressure_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_level_r   <= LOCKED_LEVEL_RST;
      unlocked_level_r <= UNLOCKED_LEVEL_RST;
      pressure_start_r <= PRESSURE_START_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOCKED_LEVEL:   locked_level_r   <= cfg_wdata[7:0];
        REG_UNLOCKED_LEVEL: unlocked_level_r <= cfg_wdata[7:0];
        REG_PRESSURE_START: pressure_start_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // working registers
  in_item_t    in_r;
  logic [7:0]  base_r;
  logic [15:0] range_r, delta_r;
  logic        cal_ok_r;
  logic [15:0] n_r, d_r;
  logic        go_r, sat_r;
  logic [15:0] rem_r;
  logic [7:0]  q_r;
  logic [15:0] prod_r;
  logic [7:0]  target_r, level_r;
  logic [3:0]  pal_r;
  logic [15:0] mr_r, mg_r, mb_r;
  logic [7:0]  key_level_r [KEYS];
  out_item_t   out_data_r;
  logic        out_valid_r;

  logic             key_ok;
  logic [KEY_W-1:0] kidx;
  assign key_ok = (32'(in_r.key_index) < KEYS);
  assign kidx   = KEY_W'(in_r.key_index);

  logic [23:0] num_w;
  assign num_w = {n_r, 8'd0} - {8'd0, n_r};

  logic [16:0] trial;
  logic        trial_ge;
  assign trial    = {rem_r, q_r[7]};
  assign trial_ge = (trial >= {1'b0, d_r});

  logic [7:0] amount;
  assign amount = !go_r ? 8'd0 : (sat_r ? 8'd255 : q_r);

  // slew toward target, then clamp to base
  logic [7:0] stored, cur, up_gap, dn_gap, dn_step, slewed, clamped;
  logic [8:0] up_half;
  always_comb begin
    stored  = key_level_r[kidx];
    cur     = (stored == 8'd0) ? base_r : stored;
    up_gap  = target_r - cur;
    dn_gap  = cur - target_r;
    up_half = (9'(up_gap) + 9'd1) >> 1;
    dn_step = 8'((9'(dn_gap) + 9'd3) >> 2);
    if (target_r > cur) begin
      slewed = cur + up_half[7:0];
    end else if (target_r < cur) begin
      slewed = (dn_step >= dn_gap) ? target_r : (cur - dn_step);
    end else begin
      slewed = cur;
    end
    clamped = (slewed < base_r) ? base_r : slewed;
  end

  rgb_t pal_rgb;
  assign pal_rgb = palette_rgb(pal_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r   <= in_data;
      base_r <= in_data.has_locks ? locked_level_r : unlocked_level_r;
    end
    if (cmd.range) begin
      cal_ok_r <= (in_r.cal_max > in_r.cal_min);
      range_r  <= in_r.cal_max - in_r.cal_min;
      delta_r  <= (in_r.reading > in_r.cal_min) ? (in_r.reading - in_r.cal_min) : 16'd0;
    end
    if (cmd.offs) begin
      go_r <= cal_ok_r && (range_r > pressure_start_r) && (delta_r > pressure_start_r);
      n_r  <= delta_r - pressure_start_r;
      d_r  <= range_r - pressure_start_r;
    end
    if (cmd.num) begin
      sat_r <= (n_r >= d_r);
      rem_r <= num_w[23:8];
      q_r   <= num_w[7:0];
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? 16'(trial - {1'b0, d_r}) : trial[15:0];
      q_r   <= {q_r[6:0], trial_ge};
    end
    if (cmd.mul) begin
      prod_r <= {8'd0, ~base_r} * {8'd0, amount};
    end
    if (cmd.tgt) begin
      target_r <= base_r + div255(prod_r);
    end
    if (cmd.slew) begin
      level_r <= key_ok ? clamped : base_r;
      pal_r   <= key_ok ? in_r.key_index : 4'd0;
    end
    if (cmd.color) begin
      mr_r <= {8'd0, pal_rgb.r} * {8'd0, level_r};
      mg_r <= {8'd0, pal_rgb.g} * {8'd0, level_r};
      mb_r <= {8'd0, pal_rgb.b} * {8'd0, level_r};
    end
    if (cmd.out_load) begin
      out_data_r <= '{level_r, div255(mr_r), div255(mg_r), div255(mb_r)};
    end
  end

  // per-key level store, zero means not yet set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEYS; i++) key_level_r[i] <= 8'd0;
    end else if (cmd.slew && key_ok) begin
      key_level_r[kidx] <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_data     = out_data_r;
  assign out_valid    = out_valid_r;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

`default_nettype wire

### design/pressure_brightness_smoother.sv
// ----------------------------------------------------------------------------
// pressure_brightness_smoother
// Per-key LED brightness smoother driven by pressure sensor readings.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one sensor reading per transaction (key, locks flag, cal min/max,
//            raw value), valid/ready handshake.
//   out_*  : one result per reading (smoothed level and palette color scaled
//            by level/255), valid/ready handshake, registered.
//   cfg_*  : write-only registers (0 locked level, 1 unlocked level,
//            2 pressure start); write only while the block is idle.
//   in_ready is high only while the sequencer is idle, so a new reading is
//   taken only after the last one has left its final step; the 8-step restoring
//   divider for the pressure mapping plus the setup, slew and color steps
//   of the shared sequencer make up each transaction.
//   A stalled receiver holds the result in the output register; the block
//   finishes the next reading and waits in its last step until the output
//   register frees, so in_ready stays low meanwhile.
//   Reset (synchronous, rst_n low) restores register defaults, clears all
//   stored key levels (read back as the base level) and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_brightness_smoother (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire pbs_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output pbs_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [pbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pbs_pkg::*;

  cmd_t cmd;   // step strobes from the sequencer
  sts_t sts;   // output register back-pressure

  pbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
